@@ src/dtv_pkg.sv @@
// ----------------------------------------------------------------------------
// dtv_pkg
// Shared types, constants and calendar tables for the datetime check and
// BCD encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dtv_pkg;

  localparam logic [13:0] YearFirst = 14'd2000;
  localparam logic [13:0] YearLast  = 14'd2099;
  localparam logic [3:0]  MonthMar  = 4'd3;
  localparam logic [3:0]  MonthDec  = 4'd12;
  localparam logic [4:0]  HourMax   = 5'd23;
  localparam logic [5:0]  MinSecMax = 6'd59;
  localparam logic [2:0]  DaySunday = 3'd7;

  // one incoming datetime word
  typedef struct packed {
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } dt_t;

  // one result word
  typedef struct packed {
    logic       valid_res;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } res_t;

  // days in month; zero for month codes that mean nothing
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      4'd2:                                       days = leap ? 5'd29 : 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

  // per-month weekday offset of the Sakamoto method
  function automatic logic [2:0] sak_offset(input logic [3:0] month);
    logic [2:0] off;
    case (month)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // two BCD digits of a value 0..99; tens by multiply with 103/1024
  function automatic logic [7:0] bcd2(input logic [6:0] value);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(value) * 14'd103;
    tens = prod[13:10];
    ones = value - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ src/dtv_in_if.sv @@
// ----------------------------------------------------------------------------
// dtv_in_if
// Valid/ready channel carrying one datetime word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtv_in_if;
  logic        valid;
  logic        ready;
  dtv_pkg::dt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/dtv_out_if.sv @@
// ----------------------------------------------------------------------------
// dtv_out_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtv_out_if;
  logic          valid;
  logic          ready;
  dtv_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/dtv_calc.sv @@
// ----------------------------------------------------------------------------
// dtv_calc
// Range check, BCD encoding and weekday of one datetime word.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_calc (
  input  dtv_pkg::dt_t  dt_i,
  output dtv_pkg::res_t res_o
);

  logic [13:0] year_off;
  logic [6:0]  ya;
  logic        year_ok, month_ok, day_ok, time_ok, ok;
  logic [4:0]  max_days;
  logic        jan_feb;
  logic [6:0]  ya_prev;
  logic [7:0]  year_term;
  logic [7:0]  wsum;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wmod;
  logic [2:0]  wday;

  assign year_off = dt_i.year_in - dtv_pkg::YearFirst;
  assign ya       = year_off[6:0];
  assign year_ok  = (dt_i.year_in >= dtv_pkg::YearFirst) && (dt_i.year_in <= dtv_pkg::YearLast);
  assign month_ok = (dt_i.month_in != 4'd0) && (dt_i.month_in <= dtv_pkg::MonthDec);

  // within 2000..2099 every fourth year is a leap year (2000 included)
  assign max_days = dtv_pkg::month_days(dt_i.month_in, ya[1:0] == 2'd0);
  assign day_ok   = (dt_i.day_in != 5'd0) && (dt_i.day_in <= max_days);
  assign time_ok  = (dt_i.hour_in <= dtv_pkg::HourMax) &&
                    (dt_i.minute_in <= dtv_pkg::MinSecMax) &&
                    (dt_i.second_in <= dtv_pkg::MinSecMax);
  assign ok       = year_ok && month_ok && day_ok && time_ok;

  // Sakamoto year term modulo 7, relative to 2000 (2000 contributes 0 mod 7);
  // January and February of 2000 fall back to 1999, which contributes 5
  assign jan_feb = dt_i.month_in < dtv_pkg::MonthMar;
  assign ya_prev = ya - 7'd1;

  always_comb begin
    if (!jan_feb) begin
      year_term = 8'(ya) + 8'(ya[6:2]);
    end else if (ya == 7'd0) begin
      year_term = 8'd5;
    end else begin
      year_term = 8'(ya_prev) + 8'(ya_prev[6:2]);
    end
  end

  assign wsum = year_term + 8'(dtv_pkg::sak_offset(dt_i.month_in)) + 8'(dt_i.day_in);

  // modulo 7 by folding octal digits (8 = 1 mod 7)
  assign fold1 = 5'(wsum[7:6]) + 5'(wsum[5:3]) + 5'(wsum[2:0]);
  assign fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
  assign wmod  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  assign wday  = (wmod == 3'd0) ? dtv_pkg::DaySunday : wmod;

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.valid_res  = 1'b1;
      res_o.year_bcd   = dtv_pkg::bcd2(ya);
      res_o.month_bcd  = 5'(dtv_pkg::bcd2(7'(dt_i.month_in)));
      res_o.day_bcd    = 6'(dtv_pkg::bcd2(7'(dt_i.day_in)));
      res_o.weekday    = wday;
      res_o.hour_bcd   = 6'(dtv_pkg::bcd2(7'(dt_i.hour_in)));
      res_o.minute_bcd = 7'(dtv_pkg::bcd2(7'(dt_i.minute_in)));
      res_o.second_bcd = 7'(dtv_pkg::bcd2(7'(dt_i.second_in)));
    end
  end

endmodule

`default_nettype wire

@@ src/datetime_validate_to_bcd.sv @@
// ----------------------------------------------------------------------------
// datetime_validate_to_bcd
// Calendar check of a decimal date and time with BCD and weekday encoding.
// ----------------------------------------------------------------------------
// Takes one decimal datetime word per clock on dt_i and returns one result
// word on res_o for each, in order. A word is valid when the year is
// 2000..2099, the month 1..12, the day within the month (Gregorian leap
// years), the hour at most 23 and minute and second at most 59; then the
// result holds two-digit BCD fields (year as offset from 2000) and the
// weekday 1 Monday .. 7 Sunday. Otherwise valid_res and every other field
// are zero. Throughput is one word per cycle while res_o is not stalled; a
// word passes the input register and then the result register, with the
// check and encode logic between them. Each register stage takes a new word
// whenever it is empty or its contents move on in the same cycle, so a
// stalled result only backs up the stages behind it once they are full.
`default_nettype none

module datetime_validate_to_bcd (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dtv_in_if.sink      dt_i,
  dtv_out_if.source   res_o
);

  // input register
  logic          in_valid_q;
  dtv_pkg::dt_t  in_data_q;
  logic          in_ready;

  // result register
  logic          res_valid_q;
  dtv_pkg::res_t res_data_q;
  logic          res_ready;
  dtv_pkg::res_t res_d;

  // advance a stage when it is empty or its word leaves this cycle
  assign res_ready  = !res_valid_q || res_o.ready;
  assign in_ready   = !in_valid_q || res_ready;
  assign dt_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= dt_i.valid;
    end
  end

  // hold the payload unless a new word is taken
  always_ff @(posedge clk_i) begin
    if (in_ready && dt_i.valid) begin
      in_data_q <= dt_i.data;
    end
  end

  // check and encode between the two registers
  dtv_calc u_calc (
    .dt_i  (in_data_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && in_valid_q) begin
      res_data_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

endmodule

`default_nettype wire
